>>> sv/lcg_pkg.sv
// Package: command codes, defaults and entry type for the recency cache.
`timescale 1ns / 1ps
`default_nettype none
package lcg_pkg;
    localparam int MAX_ENTRIES_DEF   = 16;
    localparam int GHOST_ENTRIES_DEF = 8;
    localparam int CAP_W   = 5;
    localparam int THR_W   = 16;
    localparam int CMD_W   = 3;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_GET    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUT    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GROW   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SHRINK = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b1;

    localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
    localparam logic [THR_W-1:0]  THR_RESET = 16'd2;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
        logic [CNT_W-1:0] cnt;
    } entry_t;
endpackage
`default_nettype wire

>>> sv/lru_cache_with_ghost_list.sv
// Top level: recency LRU table with ghost list, driven by a scan sequencer.
//
// Usage: requests arrive on s_ (command, key, value_in) with valid/ready; one
// result per request leaves on m_ (success, value_out, should_transform).
// Configuration writes come on cfg_ (index 0 capacity, 1 threshold) while idle.
// Each request is served by a sequencer that walks the main table and the
// ghost table one slot per cycle, comparing key and age at each slot.
// Grow and unknown commands go straight to the result; get, put, check and
// shrink scan the main then the ghost table, decide, and then as needed
// unlink a revived ghost entry, evict the main LRU into the ghost list
// (dropping the oldest ghost when it is full) and link the slot at the front.
// s_ready is high only when the sequencer is idle and no result is pending,
// so requests are served one at a time.
// A capacity write evicts one entry per round until the entry count fits.
// Reset (aresetn low, synchronous) clears all valid bits and ages, loads
// capacity 16 and threshold 2. Entry contents stay undefined until written.
// When the receiver stalls, the result holds in the output register and the
// sequencer waits; no new request is taken until the result is delivered.
`timescale 1ns / 1ps
`default_nettype none
module lru_cache_with_ghost_list #(
    parameter int MAX_ENTRIES   = lcg_pkg::MAX_ENTRIES_DEF,
    parameter int GHOST_ENTRIES = lcg_pkg::GHOST_ENTRIES_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [lcg_pkg::CMD_W-1:0]  s_command,
    input  wire logic [lcg_pkg::KEY_W-1:0]  s_key,
    input  wire logic [lcg_pkg::VAL_W-1:0]  s_value_in,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic                            m_success,
    output logic [lcg_pkg::VAL_W-1:0]       m_value_out,
    output logic                            m_should_transform,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [lcg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                cfg_data
);
    import lcg_pkg::*;

    localparam int MI_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int GI_W = (GHOST_ENTRIES > 1) ? $clog2(GHOST_ENTRIES) : 1;
    localparam int MA_W = MI_W;
    localparam int GA_W = GI_W;
    localparam int MC_W = $clog2(MAX_ENTRIES + 1);
    localparam int GC_W = $clog2(GHOST_ENTRIES + 1);
    localparam int SC_W = (MI_W > GI_W) ? MI_W : GI_W;

    // Sequencer states, one-hot.
    typedef enum logic [10:0] {
        ST_IDLE     = 11'b00000000001,
        ST_MSCAN    = 11'b00000000010, // find key in main, oldest, free slot
        ST_GSCAN    = 11'b00000000100, // find key in ghost, oldest, free slot
        ST_DECIDE   = 11'b00000001000,
        ST_EV_MAIN  = 11'b00000010000, // unlink main LRU (age ripple pass)
        ST_EV_GDROP = 11'b00000100000, // unlink oldest ghost
        ST_EV_GLINK = 11'b00001000000, // push evicted entry at ghost front
        ST_GUNLINK  = 11'b00010000000, // unlink revived ghost entry
        ST_MLINK    = 11'b00100000000, // link main slot at front
        ST_RESULT   = 11'b01000000000,
        ST_CFGEV    = 11'b10000000000  // capacity reload eviction loop
    } state_t;

    // Entry storage: one write and one read address per cycle.
    entry_t main_mem [MAX_ENTRIES];
    entry_t ghost_mem [GHOST_ENTRIES];
    logic [MAX_ENTRIES-1:0]   mvalid_reg;
    logic [MA_W-1:0]          mage_reg [MAX_ENTRIES];
    logic [GHOST_ENTRIES-1:0] gvalid_reg;
    logic [GA_W-1:0]          gage_reg [GHOST_ENTRIES];

    state_t state_reg;
    logic [MC_W-1:0]  cap_reg;
    logic [THR_W-1:0] thr_reg;
    logic [CMD_W-1:0] cmd_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;
    logic [SC_W-1:0]  idx_reg;       // scan pointer
    logic [MC_W-1:0]  mcount_reg;
    logic [GC_W-1:0]  gcount_reg;

    // Scan findings.
    logic             mhit_reg, ghit_reg;
    logic [MI_W-1:0]  mhit_idx_reg, mold_idx_reg, mfree_idx_reg;
    logic [GI_W-1:0]  ghit_idx_reg, gold_idx_reg, gfree_idx_reg;
    logic             mfree_ok_reg, gfree_ok_reg;
    logic [MA_W-1:0]  mold_age_reg;
    logic [GA_W-1:0]  gold_age_reg;

    // Plan for the current request.
    logic             do_evict_reg;   // evict main LRU
    logic             do_revive_reg;  // move ghost hit to main
    logic             new_entry_reg;  // link writes a fresh entry from put
    logic [MI_W-1:0]  link_idx_reg;
    logic [MA_W-1:0]  link_age_reg;   // age of slot before relink
    logic             link_relink_reg;// slot is already valid (touch)
    logic             gsel_done_reg;
    entry_t           carry_reg;      // entry in flight between tables
    logic             sub_reg;        // marks a capacity-reload round
    logic             drop_done_reg;

    // Result register.
    logic             m_valid_reg;
    logic             res_ok_reg, res_st_reg;
    logic [VAL_W-1:0] res_val_reg;

    // Read port register.
    entry_t mrd_reg;
    logic [MI_W-1:0] mi;
    logic [GI_W-1:0] gi;
    assign mi = idx_reg[MI_W-1:0];
    assign gi = idx_reg[GI_W-1:0];

    logic mlast, glast;
    assign mlast = (mi == MI_W'(MAX_ENTRIES - 1));
    assign glast = (gi == GI_W'(GHOST_ENTRIES - 1));

    logic [MC_W-1:0] cfg_cap_sat;
    assign cfg_cap_sat = (int'(cfg_data[CAP_W-1:0]) > MAX_ENTRIES)
                       ? MC_W'(MAX_ENTRIES) : MC_W'(cfg_data[CAP_W-1:0]);

    logic main_full;
    assign main_full = (32'(mcount_reg) >= 32'(cap_reg));

    assign s_ready   = (state_reg == ST_IDLE) && !m_valid_reg;
    assign cfg_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_valid   = m_valid_reg;
    assign m_success = res_ok_reg;
    assign m_value_out = res_val_reg;
    assign m_should_transform = res_st_reg;

    // Saturating count increment on the carried entry.
    logic [CNT_W-1:0] cnt_inc;
    assign cnt_inc = (carry_reg.cnt == '1) ? carry_reg.cnt : carry_reg.cnt + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mvalid_reg  <= '0;
            gvalid_reg  <= '0;
            for (int k = 0; k < MAX_ENTRIES; k++) mage_reg[k] <= '0;
            for (int k = 0; k < GHOST_ENTRIES; k++) gage_reg[k] <= '0;
            cap_reg     <= (int'(CAP_RESET) > MAX_ENTRIES) ? MC_W'(MAX_ENTRIES)
                                                          : MC_W'(CAP_RESET);
            thr_reg     <= THR_RESET;
            mcount_reg  <= '0;
            gcount_reg  <= '0;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
            sub_reg     <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    idx_reg <= '0;
                    sub_reg <= 1'b0;
                    if (cfg_valid && cfg_ready) begin
                        if (cfg_index == REG_CAPACITY) begin
                            cap_reg   <= cfg_cap_sat;
                            state_reg <= ST_CFGEV;
                        end else if (cfg_index == REG_THRESHOLD) begin
                            thr_reg <= cfg_data[THR_W-1:0];
                        end
                    end else if (s_valid && s_ready) begin
                        cmd_reg <= s_command;
                        key_reg <= s_key;
                        val_reg <= s_value_in;
                        res_ok_reg <= 1'b0;
                        res_st_reg <= 1'b0;
                        res_val_reg <= '0;
                        mhit_reg <= 1'b0; ghit_reg <= 1'b0;
                        mfree_ok_reg <= 1'b0; gfree_ok_reg <= 1'b0;
                        mold_age_reg <= '0; gold_age_reg <= '0;
                        mold_idx_reg <= '0; gold_idx_reg <= '0;
                        if (s_command == CMD_GROW) begin
                            if (32'(cap_reg) < 32'(MAX_ENTRIES)) begin
                                cap_reg    <= cap_reg + 1'b1;
                                res_ok_reg <= 1'b1;
                            end
                            state_reg <= ST_RESULT;
                        end else if (s_command == CMD_SHRINK ||
                                     s_command == CMD_GET ||
                                     s_command == CMD_PUT ||
                                     s_command == CMD_CHECK) begin
                            state_reg <= ST_MSCAN;
                        end else begin
                            state_reg <= ST_RESULT;
                        end
                    end
                end
                ST_CFGEV: begin
                    // Reload capacity: evict one LRU per round until it fits.
                    if (32'(mcount_reg) > 32'(cap_reg)) begin
                        cmd_reg <= CMD_SHRINK; // reuse eviction path, no result
                        key_reg <= '0;
                        mhit_reg <= 1'b0; ghit_reg <= 1'b0;
                        mfree_ok_reg <= 1'b0; gfree_ok_reg <= 1'b0;
                        mold_age_reg <= '0; gold_age_reg <= '0;
                        mold_idx_reg <= '0; gold_idx_reg <= '0;
                        idx_reg <= '0;
                        do_evict_reg  <= 1'b1;
                        do_revive_reg <= 1'b0;
                        state_reg <= ST_MSCAN;
                        sub_reg   <= 1'b1; // marks a configuration round
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_MSCAN: begin
                    // One slot a cycle: key match, oldest valid, first free.
                    if (mvalid_reg[mi]) begin
                        if (!mhit_reg && main_mem[mi].key == key_reg) begin
                            mhit_reg <= 1'b1;
                            mhit_idx_reg <= mi;
                        end
                        if (mage_reg[mi] >= mold_age_reg) begin
                            mold_age_reg <= mage_reg[mi];
                            mold_idx_reg <= mi;
                        end
                    end else if (!mfree_ok_reg) begin
                        mfree_ok_reg  <= 1'b1;
                        mfree_idx_reg <= mi;
                    end
                    if (mlast) begin
                        idx_reg <= '0;
                        state_reg <= ST_GSCAN;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_GSCAN: begin
                    if (gvalid_reg[gi]) begin
                        if (!ghit_reg && ghost_mem[gi].key == key_reg) begin
                            ghit_reg <= 1'b1;
                            ghit_idx_reg <= gi;
                        end
                        if (gage_reg[gi] >= gold_age_reg) begin
                            gold_age_reg <= gage_reg[gi];
                            gold_idx_reg <= gi;
                        end
                    end else if (!gfree_ok_reg) begin
                        gfree_ok_reg  <= 1'b1;
                        gfree_idx_reg <= gi;
                    end
                    if (glast) begin
                        idx_reg <= '0;
                        state_reg <= sub_reg ? ST_EV_MAIN : ST_DECIDE;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_DECIDE: begin
                    do_evict_reg    <= 1'b0;
                    do_revive_reg   <= 1'b0;
                    new_entry_reg   <= 1'b0;
                    link_relink_reg <= 1'b0;
                    idx_reg         <= '0;
                    state_reg       <= ST_RESULT;
                    case (cmd_reg)
                        CMD_GET, CMD_PUT: begin
                            if (mhit_reg) begin
                                link_relink_reg <= 1'b1;
                                link_idx_reg    <= mhit_idx_reg;
                                link_age_reg    <= mage_reg[mhit_idx_reg];
                                carry_reg       <= main_mem[mhit_idx_reg];
                                state_reg       <= ST_MLINK;
                            end else if (ghit_reg) begin
                                if (cap_reg != '0) begin
                                    do_revive_reg <= 1'b1;
                                    do_evict_reg  <= main_full;
                                    carry_reg     <= ghost_mem[ghit_idx_reg];
                                    state_reg     <= ST_GUNLINK;
                                end
                            end else if (cmd_reg == CMD_PUT && cap_reg != '0) begin
                                do_evict_reg  <= main_full;
                                new_entry_reg <= 1'b1;
                                carry_reg     <= '{key: key_reg, val: val_reg, cnt: '0};
                                state_reg     <= main_full ? ST_EV_MAIN : ST_MLINK;
                                link_idx_reg  <= mfree_idx_reg;
                            end
                        end
                        CMD_CHECK: begin
                            if (ghit_reg) begin
                                if (cap_reg != '0) begin
                                    do_revive_reg <= 1'b1;
                                    do_evict_reg  <= main_full;
                                    carry_reg     <= ghost_mem[ghit_idx_reg];
                                    state_reg     <= ST_GUNLINK;
                                end
                            end else if (main_full && mcount_reg != '0) begin
                                do_evict_reg <= 1'b1;
                                state_reg    <= ST_EV_MAIN;
                            end
                        end
                        CMD_SHRINK: begin
                            if (cap_reg != '0) begin
                                cap_reg    <= cap_reg - 1'b1;
                                res_ok_reg <= 1'b1;
                                if (main_full && mcount_reg != '0) begin
                                    do_evict_reg <= 1'b1;
                                    state_reg    <= ST_EV_MAIN;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                ST_GUNLINK: begin
                    // Drop revived entry from ghost: age ripple, one slot a cycle.
                    if (gvalid_reg[gi] && gi != ghit_idx_reg &&
                        gage_reg[gi] > gage_reg[ghit_idx_reg]) begin
                        gage_reg[gi] <= gage_reg[gi] - 1'b1;
                    end
                    if (glast) begin
                        gvalid_reg[ghit_idx_reg] <= 1'b0;
                        gage_reg[ghit_idx_reg]   <= '0;
                        gcount_reg <= gcount_reg - 1'b1;
                        // Ghost oldest may have shifted; rescan if evicting.
                        idx_reg <= '0;
                        if (do_evict_reg) begin
                            state_reg <= ST_EV_MAIN;
                        end else begin
                            link_idx_reg <= mfree_idx_reg;
                            state_reg    <= ST_MLINK;
                        end
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_EV_MAIN: begin
                    // Unlink main LRU, keep it in mrd for the ghost push.
                    if (mvalid_reg[mi] && mi != mold_idx_reg &&
                        mage_reg[mi] > mage_reg[mold_idx_reg]) begin
                        mage_reg[mi] <= mage_reg[mi] - 1'b1;
                    end
                    if (mlast) begin
                        mvalid_reg[mold_idx_reg] <= 1'b0;
                        mage_reg[mold_idx_reg]   <= '0;
                        mcount_reg <= mcount_reg - 1'b1;
                        mrd_reg    <= main_mem[mold_idx_reg];
                        link_idx_reg <= mold_idx_reg; // freed slot serves next link
                        idx_reg    <= '0;
                        drop_done_reg <= 1'b0;
                        gsel_done_reg <= 1'b0;
                        state_reg  <= ST_EV_GDROP;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_EV_GDROP: begin
                    if (!gsel_done_reg) begin
                        // Re-find ghost oldest and free slot after any unlink.
                        if (gvalid_reg[gi] && (gi == '0 || gage_reg[gi] >= gold_age_reg)) begin
                            gold_age_reg <= gage_reg[gi];
                            gold_idx_reg <= gi;
                        end else if (gi == '0) begin
                            gold_age_reg <= '0;
                            gold_idx_reg <= '0;
                        end
                        if (!gvalid_reg[gi] && (gi == '0 || !gfree_ok_reg)) begin
                            gfree_ok_reg  <= 1'b1;
                            gfree_idx_reg <= gi;
                        end else if (gi == '0) begin
                            gfree_ok_reg <= 1'b0;
                        end
                        if (glast) begin
                            gsel_done_reg <= 1'b1;
                            idx_reg <= '0;
                            drop_done_reg <= ({{(32-GC_W){1'b0}}, gcount_reg} < GHOST_ENTRIES);
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end else if (!drop_done_reg) begin
                        if (gvalid_reg[gi] && gi != gold_idx_reg &&
                            gage_reg[gi] > gage_reg[gold_idx_reg]) begin
                            gage_reg[gi] <= gage_reg[gi] - 1'b1;
                        end
                        if (glast) begin
                            gvalid_reg[gold_idx_reg] <= 1'b0;
                            gage_reg[gold_idx_reg]   <= '0;
                            gcount_reg    <= gcount_reg - 1'b1;
                            gfree_idx_reg <= gold_idx_reg;
                            gfree_ok_reg  <= 1'b1;
                            drop_done_reg <= 1'b1;
                            idx_reg <= '0;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end else begin
                        ghost_mem[gfree_idx_reg] <= mrd_reg;
                        idx_reg   <= '0;
                        state_reg <= ST_EV_GLINK;
                    end
                end
                ST_EV_GLINK: begin
                    // Age every other valid ghost entry, new one goes to front.
                    if (gvalid_reg[gi] && gi != gfree_idx_reg) begin
                        gage_reg[gi] <= gage_reg[gi] + 1'b1;
                    end
                    if (glast) begin
                        gvalid_reg[gfree_idx_reg] <= 1'b1;
                        gage_reg[gfree_idx_reg]   <= '0;
                        gcount_reg <= gcount_reg + 1'b1;
                        idx_reg    <= '0;
                        if (sub_reg) begin
                            state_reg <= ST_CFGEV;
                        end else if (do_revive_reg || new_entry_reg) begin
                            state_reg <= ST_MLINK;
                        end else begin
                            state_reg <= ST_RESULT;
                        end
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_MLINK: begin
                    // Move slot to front: bump younger (relink) or all (new or revived).
                    if (mvalid_reg[mi] && mi != link_idx_reg &&
                        (!link_relink_reg || mage_reg[mi] < link_age_reg)) begin
                        mage_reg[mi] <= mage_reg[mi] + 1'b1;
                    end
                    if (mlast) begin
                        idx_reg <= '0;
                        mvalid_reg[link_idx_reg] <= 1'b1;
                        mage_reg[link_idx_reg]   <= '0;
                        if (!link_relink_reg) mcount_reg <= mcount_reg + 1'b1;
                        begin
                            entry_t e;
                            e = carry_reg;
                            if (new_entry_reg) begin
                                e.cnt = {{(CNT_W-1){1'b0}}, 1'b1};
                            end else begin
                                // A plain ghost check revives without counting an access.
                                if (cmd_reg != CMD_CHECK) e.cnt = cnt_inc;
                                if (cmd_reg == CMD_PUT) e.val = val_reg;
                            end
                            main_mem[link_idx_reg] <= e;
                            if (cmd_reg == CMD_GET) begin
                                res_ok_reg  <= 1'b1;
                                res_val_reg <= e.val;
                                res_st_reg  <= (e.cnt >= {{(CNT_W-THR_W){1'b0}}, thr_reg});
                            end else if (cmd_reg == CMD_PUT) begin
                                res_st_reg  <= (e.cnt >= {{(CNT_W-THR_W){1'b0}}, thr_reg});
                            end else begin
                                res_ok_reg  <= 1'b1;
                            end
                        end
                        state_reg <= ST_RESULT;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_RESULT: begin
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // The free slot of a revival after eviction is the freed LRU slot, else
    // the first free slot found in the scan (both captured in link_idx_reg).

    // Valid counters agree with the valid bits whenever idle.
    a_mcount: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> ($countones(mvalid_reg) == 32'(mcount_reg)))
        else $error("main count mismatch");
    a_gcount: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> ($countones(gvalid_reg) == 32'(gcount_reg)))
        else $error("ghost count mismatch");
    a_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (32'(mcount_reg) <= 32'(cap_reg)))
        else $error("main over capacity");
    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("state not one-hot");
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESULT) |=> m_valid_reg)
        else $error("result not posted");
endmodule
`default_nettype wire
